// ----- rtl/snmprp_pkg.sv -----
package snmprp_pkg;

	localparam int FLEN_W = 11;
	localparam int POS_W  = 12;

	typedef enum logic [21:0] {
		PH_OUTER_TAG  = 22'h000001,
		PH_LEN_FIRST  = 22'h000002,
		PH_LEN_MORE   = 22'h000004,
		PH_VER_TAG    = 22'h000008,
		PH_INT_FIRST  = 22'h000010,
		PH_INT_SIZE   = 22'h000020,
		PH_INT_BYTES  = 22'h000040,
		PH_COMM_TAG   = 22'h000080,
		PH_COMM_TEXT  = 22'h000100,
		PH_PDU_TAG    = 22'h000200,
		PH_REQID_TAG  = 22'h000400,
		PH_ERR_TAG    = 22'h000800,
		PH_IDX_TAG    = 22'h001000,
		PH_OBJ1_TAG   = 22'h002000,
		PH_QUIRK_B    = 22'h004000,
		PH_QUIRK_C    = 22'h008000,
		PH_OBJ1_PLAIN = 22'h010000,
		PH_OBJ2_TAG   = 22'h020000,
		PH_OID_TAG    = 22'h040000,
		PH_OID_SKIP   = 22'h080000,
		PH_VAL_TAG    = 22'h100000,
		PH_VAL_TEXT   = 22'h200000
	} phase_t;

	typedef enum logic [3:0] {
		OW_OUTER = 4'd0,
		OW_COMM  = 4'd1,
		OW_PDU   = 4'd2,
		OW_OBJ1  = 4'd3,
		OW_OBJ2  = 4'd4,
		OW_OID   = 4'd5,
		OW_VAL   = 4'd6,
		OW_VER   = 4'd7,
		OW_REQID = 4'd8,
		OW_ERR   = 4'd9,
		OW_IDX   = 4'd10
	} owner_t;

	typedef enum logic [1:0] {
		KIND_COMM   = 2'd0,
		KIND_VAL    = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_OK        = 4'd0,
		ST_TRUNC     = 4'd1,
		ST_HEADER    = 4'd2,
		ST_LENFORM   = 4'd3,
		ST_VERSION   = 4'd4,
		ST_COMMUNITY = 4'd5,
		ST_PDU       = 4'd6,
		ST_REQID     = 4'd7,
		ST_INTLEN    = 4'd8,
		ST_ERRCODE   = 4'd9,
		ST_HOSTERR   = 4'd10,
		ST_ERRINDEX  = 4'd11,
		ST_OBJHDR    = 4'd12,
		ST_VALUE     = 4'd13,
		ST_NEG       = 4'd14
	} status_t;

	localparam logic [7:0] TAG_SEQ      = 8'h30;
	localparam logic [7:0] TAG_INT      = 8'h02;
	localparam logic [7:0] TAG_OCTETS   = 8'h04;
	localparam logic [7:0] TAG_OID      = 8'h06;
	localparam logic [7:0] TAG_PDU      = 8'ha2;
	localparam logic [7:0] LEN_LONG_MIN = 8'h81;
	localparam logic [7:0] LEN_LONG_MAX = 8'h84;
	localparam logic [7:0] INT_PREFIX   = 8'h81;
	localparam logic [7:0] QUIRK_LEAD   = 8'h00;
	localparam logic [7:0] QUIRK_MID    = 8'h30;
	localparam logic [7:0] QUIRK_LAST   = 8'h20;
	localparam logic [7:0] SPACE_CHAR   = 8'h20;
	localparam logic [7:0] TEXT_MAX     = 8'h80;
	localparam logic [31:0] HOST_ERR_MAX = 32'd18;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] text;
		status_t    status;
		logic [4:0] code;
		logic       last;
	} result_t;

	function automatic logic [7:0] clean_char(input logic [7:0] b);
		return (b < SPACE_CHAR || b > TEXT_MAX) ? SPACE_CHAR : b;
	endfunction

endpackage

// ----- rtl/snmprp_parse.sv -----
module snmprp_parse (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic [7:0]                        rx_byte,
	input  logic [snmprp_pkg::FLEN_W-1:0]     flen,
	input  logic                              eof,
	output snmprp_pkg::result_t               res0,
	output snmprp_pkg::result_t               res1,
	output logic [1:0]                        res_n
);

	snmprp_pkg::phase_t               phase_q, phase_d;
	snmprp_pkg::owner_t               owner_q, owner_d;
	logic [snmprp_pkg::POS_W-1:0]     pos_q, pos_d;
	logic [31:0]                      len_q, len_d;
	logic [31:0]                      int_q, int_d;
	logic [2:0]                       left_q, left_d;
	logic [snmprp_pkg::FLEN_W-1:0]    fend_q, fend_d;
	logic                             decided_q, decided_d;

	logic                             dec;
	snmprp_pkg::status_t              dst;
	logic [4:0]                       dcode;
	logic                             txt_v;
	snmprp_pkg::kind_t                txt_kind;
	logic                             do_fin, do_int, do_isz;
	logic [12:0]                      p13, fl13, fin_end;
	logic [31:0]                      fin_len, int_val;
	logic                             fin_over, small_over, at_end, quirk_fits;
	snmprp_pkg::result_t              stat_res, text_res;

	always_comb begin
		p13        = {1'b0, pos_q};
		fl13       = {2'b00, flen};
		fin_len    = (phase_q == snmprp_pkg::PH_LEN_MORE) ? {len_q[23:0], rx_byte}
			: {24'd0, rx_byte};
		fin_end    = p13 + 13'd1 + {2'b00, fin_len[10:0]};
		fin_over   = (|fin_len[30:11]) || (fin_end > fl13);
		int_val    = {int_q[23:0], rx_byte};
		small_over = (p13 + 13'd1 + {10'd0, rx_byte[2:0]}) > fl13;
		at_end     = (p13 + 13'd1) >= {2'b00, fend_q};
		quirk_fits = (p13 + 13'd3) <= fl13;

		phase_d   = phase_q;
		owner_d   = owner_q;
		len_d     = len_q;
		int_d     = int_q;
		left_d    = left_q;
		fend_d    = fend_q;
		dec       = 1'b0;
		dst       = snmprp_pkg::ST_OK;
		dcode     = 5'd0;
		txt_v     = 1'b0;
		txt_kind  = snmprp_pkg::KIND_COMM;
		do_fin    = 1'b0;
		do_int    = 1'b0;
		do_isz    = 1'b0;

		if (!decided_q) begin
			if (p13 >= fl13) begin
				dec = 1'b1;
				dst = snmprp_pkg::ST_TRUNC;
			end else begin
				unique case (phase_q)
					snmprp_pkg::PH_OUTER_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_SEQ) begin
							owner_d = snmprp_pkg::OW_OUTER;
							phase_d = snmprp_pkg::PH_LEN_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_HEADER;
						end
					end
					snmprp_pkg::PH_LEN_FIRST: begin
						if (rx_byte < snmprp_pkg::LEN_LONG_MIN) begin
							do_fin = 1'b1;
						end else if (rx_byte <= snmprp_pkg::LEN_LONG_MAX) begin
							if (small_over) begin
								dec = 1'b1;
								dst = snmprp_pkg::ST_TRUNC;
							end else begin
								left_d  = rx_byte[2:0];
								len_d   = 32'd0;
								phase_d = snmprp_pkg::PH_LEN_MORE;
							end
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_LENFORM;
						end
					end
					snmprp_pkg::PH_LEN_MORE: begin
						len_d  = fin_len;
						left_d = left_q - 3'd1;
						if (left_q == 3'd1) begin
							do_fin = 1'b1;
						end
					end
					snmprp_pkg::PH_VER_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_INT) begin
							owner_d = snmprp_pkg::OW_VER;
							phase_d = snmprp_pkg::PH_INT_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_VERSION;
						end
					end
					snmprp_pkg::PH_INT_FIRST: begin
						if (rx_byte == snmprp_pkg::INT_PREFIX) begin
							phase_d = snmprp_pkg::PH_INT_SIZE;
						end else begin
							do_isz = 1'b1;
						end
					end
					snmprp_pkg::PH_INT_SIZE: begin
						do_isz = 1'b1;
					end
					snmprp_pkg::PH_INT_BYTES: begin
						int_d  = int_val;
						left_d = left_q - 3'd1;
						if (left_q == 3'd1) begin
							do_int = 1'b1;
						end
					end
					snmprp_pkg::PH_COMM_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_OCTETS) begin
							owner_d = snmprp_pkg::OW_COMM;
							phase_d = snmprp_pkg::PH_LEN_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_COMMUNITY;
						end
					end
					snmprp_pkg::PH_COMM_TEXT: begin
						txt_v    = 1'b1;
						txt_kind = snmprp_pkg::KIND_COMM;
						if (at_end) begin
							phase_d = snmprp_pkg::PH_PDU_TAG;
						end
					end
					snmprp_pkg::PH_PDU_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_PDU) begin
							owner_d = snmprp_pkg::OW_PDU;
							phase_d = snmprp_pkg::PH_LEN_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_PDU;
						end
					end
					snmprp_pkg::PH_REQID_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_INT) begin
							owner_d = snmprp_pkg::OW_REQID;
							phase_d = snmprp_pkg::PH_INT_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_REQID;
						end
					end
					snmprp_pkg::PH_ERR_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_INT) begin
							owner_d = snmprp_pkg::OW_ERR;
							phase_d = snmprp_pkg::PH_INT_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_ERRCODE;
						end
					end
					snmprp_pkg::PH_IDX_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_INT) begin
							owner_d = snmprp_pkg::OW_IDX;
							phase_d = snmprp_pkg::PH_INT_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_ERRINDEX;
						end
					end
					snmprp_pkg::PH_OBJ1_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_SEQ) begin
							owner_d = snmprp_pkg::OW_OBJ1;
							phase_d = snmprp_pkg::PH_LEN_FIRST;
						end else if (rx_byte == snmprp_pkg::QUIRK_LEAD && quirk_fits) begin
							phase_d = snmprp_pkg::PH_QUIRK_B;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_OBJHDR;
						end
					end
					snmprp_pkg::PH_QUIRK_B: begin
						if (rx_byte == snmprp_pkg::QUIRK_MID) begin
							phase_d = snmprp_pkg::PH_QUIRK_C;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_OBJHDR;
						end
					end
					snmprp_pkg::PH_QUIRK_C: begin
						if (rx_byte == snmprp_pkg::QUIRK_LAST) begin
							phase_d = snmprp_pkg::PH_OBJ1_PLAIN;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_OBJHDR;
						end
					end
					snmprp_pkg::PH_OBJ1_PLAIN: begin
						if (rx_byte == snmprp_pkg::TAG_SEQ) begin
							owner_d = snmprp_pkg::OW_OBJ1;
							phase_d = snmprp_pkg::PH_LEN_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_OBJHDR;
						end
					end
					snmprp_pkg::PH_OBJ2_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_SEQ) begin
							owner_d = snmprp_pkg::OW_OBJ2;
							phase_d = snmprp_pkg::PH_LEN_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_OBJHDR;
						end
					end
					snmprp_pkg::PH_OID_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_OID) begin
							owner_d = snmprp_pkg::OW_OID;
							phase_d = snmprp_pkg::PH_LEN_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_OBJHDR;
						end
					end
					snmprp_pkg::PH_OID_SKIP: begin
						if (at_end) begin
							phase_d = snmprp_pkg::PH_VAL_TAG;
						end
					end
					snmprp_pkg::PH_VAL_TAG: begin
						if (rx_byte == snmprp_pkg::TAG_OCTETS) begin
							owner_d = snmprp_pkg::OW_VAL;
							phase_d = snmprp_pkg::PH_LEN_FIRST;
						end else begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_VALUE;
						end
					end
					snmprp_pkg::PH_VAL_TEXT: begin
						txt_v    = 1'b1;
						txt_kind = snmprp_pkg::KIND_VAL;
						if (at_end) begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_OK;
						end
					end
					default: begin
						dec = 1'b1;
						dst = snmprp_pkg::ST_HEADER;
					end
				endcase

				if (do_isz) begin
					if (rx_byte == 8'd1 || rx_byte == 8'd2 || rx_byte == 8'd4) begin
						if (small_over) begin
							dec = 1'b1;
							dst = snmprp_pkg::ST_TRUNC;
						end else begin
							left_d  = rx_byte[2:0];
							int_d   = 32'd0;
							phase_d = snmprp_pkg::PH_INT_BYTES;
						end
					end else begin
						dec = 1'b1;
						dst = snmprp_pkg::ST_INTLEN;
					end
				end

				if (do_fin) begin
					if (fin_len[31]) begin
						dec = 1'b1;
						dst = snmprp_pkg::ST_NEG;
					end else if (fin_over) begin
						dec = 1'b1;
						dst = snmprp_pkg::ST_TRUNC;
					end else begin
						fend_d = fin_end[snmprp_pkg::FLEN_W-1:0];
						case (owner_q)
							snmprp_pkg::OW_OUTER: phase_d = snmprp_pkg::PH_VER_TAG;
							snmprp_pkg::OW_COMM: phase_d = (|fin_len) ?
								snmprp_pkg::PH_COMM_TEXT : snmprp_pkg::PH_PDU_TAG;
							snmprp_pkg::OW_PDU: phase_d = snmprp_pkg::PH_REQID_TAG;
							snmprp_pkg::OW_OBJ1: phase_d = snmprp_pkg::PH_OBJ2_TAG;
							snmprp_pkg::OW_OBJ2: phase_d = snmprp_pkg::PH_OID_TAG;
							snmprp_pkg::OW_OID: phase_d = (|fin_len) ?
								snmprp_pkg::PH_OID_SKIP : snmprp_pkg::PH_VAL_TAG;
							default: begin
								if (|fin_len) begin
									phase_d = snmprp_pkg::PH_VAL_TEXT;
								end else begin
									dec = 1'b1;
									dst = snmprp_pkg::ST_OK;
								end
							end
						endcase
					end
				end

				if (do_int) begin
					case (owner_q)
						snmprp_pkg::OW_VER: begin
							if (int_val != 32'd0) begin
								dec = 1'b1;
								dst = snmprp_pkg::ST_VERSION;
							end else begin
								phase_d = snmprp_pkg::PH_COMM_TAG;
							end
						end
						snmprp_pkg::OW_REQID: begin
							if (int_val[31]) begin
								dec = 1'b1;
								dst = snmprp_pkg::ST_NEG;
							end else begin
								phase_d = snmprp_pkg::PH_ERR_TAG;
							end
						end
						snmprp_pkg::OW_ERR: begin
							if (int_val[31]) begin
								dec = 1'b1;
								dst = snmprp_pkg::ST_NEG;
							end else if (int_val > snmprp_pkg::HOST_ERR_MAX) begin
								dec = 1'b1;
								dst = snmprp_pkg::ST_ERRCODE;
							end else if (int_val != 32'd0) begin
								dec   = 1'b1;
								dst   = snmprp_pkg::ST_HOSTERR;
								dcode = int_val[4:0];
							end else begin
								phase_d = snmprp_pkg::PH_IDX_TAG;
							end
						end
						default: begin
							if (int_val[31]) begin
								dec = 1'b1;
								dst = snmprp_pkg::ST_NEG;
							end else begin
								phase_d = snmprp_pkg::PH_OBJ1_TAG;
							end
						end
					endcase
				end
			end
		end

		decided_d = decided_q | dec;
		pos_d     = pos_q[snmprp_pkg::POS_W-1] ? pos_q
			: pos_q + {{(snmprp_pkg::POS_W-1){1'b0}}, 1'b1};

		if (eof) begin
			if (!decided_q && !dec) begin
				dec = 1'b1;
				dst = snmprp_pkg::ST_TRUNC;
			end
			phase_d   = snmprp_pkg::PH_OUTER_TAG;
			owner_d   = snmprp_pkg::OW_OUTER;
			pos_d     = '0;
			len_d     = 32'd0;
			int_d     = 32'd0;
			left_d    = 3'd0;
			fend_d    = '0;
			decided_d = 1'b0;
		end

		stat_res = '{kind: snmprp_pkg::KIND_STATUS, text: 8'h00, status: dst,
			code: dcode, last: 1'b1};
		text_res = '{kind: txt_kind, text: snmprp_pkg::clean_char(rx_byte),
			status: snmprp_pkg::ST_OK, code: 5'd0, last: !dec};
		res0  = txt_v ? text_res : stat_res;
		res1  = stat_res;
		res_n = {1'b0, txt_v} + {1'b0, dec};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= snmprp_pkg::PH_OUTER_TAG;
			owner_q   <= snmprp_pkg::OW_OUTER;
			pos_q     <= '0;
			len_q     <= 32'd0;
			int_q     <= 32'd0;
			left_q    <= 3'd0;
			fend_q    <= '0;
			decided_q <= 1'b0;
		end else if (go) begin
			phase_q   <= phase_d;
			owner_q   <= owner_d;
			pos_q     <= pos_d;
			len_q     <= len_d;
			int_q     <= int_d;
			left_q    <= left_d;
			fend_q    <= fend_d;
			decided_q <= decided_d;
		end
	end

endmodule

// ----- rtl/snmprp_rqueue.sv -----
module snmprp_rqueue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  snmprp_pkg::result_t d0,
	input  snmprp_pkg::result_t d1,
	input  logic                pop,
	output snmprp_pkg::result_t head,
	output logic [2:0]          level
);

	snmprp_pkg::result_t entry_q [4];
	logic [1:0]          wr_q, rd_q;
	logic [1:0]          wr_next;

	assign head    = entry_q[rd_q];
	assign wr_next = wr_q + 2'd1;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			entry_q[wr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			entry_q[wr_next] <= d1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			level <= 3'd0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + {1'b0, pop};
			level <= level + {1'b0, push_n} - {2'b00, pop};
		end
	end

endmodule

// ----- rtl/snmp_response_parser.sv -----
// Parses one SNMPv1 GetResponse datagram per frame, one byte per clock. Each byte
// is captured in an input register, decoded from that register by the BER phase
// logic, and its results go to a four-entry result queue that feeds the output
// port. A byte yields at most two results (a text byte and then the frame status),
// so sustained rate is one byte per cycle while the output side takes a result
// each cycle; a byte with two results writes both into the queue together, and a
// byte waiting in the input register is held while the queue holds more than two
// results. Results are registered in the queue before they reach the output port.
// Frame length is capped at MAX_FRAME_BYTES.
module snmp_response_parser #(
	parameter int unsigned MAX_FRAME_BYTES = 1500
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  rx_byte,
	input  logic [10:0] frame_length,
	input  logic        end_of_frame,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  text_byte,
	output logic [3:0]  status,
	output logic [4:0]  host_error_code,
	output logic        last_result
);

	localparam logic [16:0] MAX_LEN = 17'(MAX_FRAME_BYTES);

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic [snmprp_pkg::FLEN_W-1:0] flen_s1;
	logic                          eof_s1;
	logic [snmprp_pkg::FLEN_W-1:0] flen_cap;
	logic                          take, commit, room, pop;
	logic [2:0]                    level;
	logic [1:0]                    res_n, push_n;
	snmprp_pkg::result_t           res0, res1, head;

	assign flen_cap = ({6'd0, frame_length} > MAX_LEN) ?
		MAX_LEN[snmprp_pkg::FLEN_W-1:0] : frame_length;

	assign room       = level <= 3'd2;
	assign commit     = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign take       = byte_valid && !byte_stall;
	assign push_n     = commit ? res_n : 2'd0;
	assign pop        = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
			flen_s1 <= flen_cap;
			eof_s1  <= end_of_frame;
		end
	end

	snmprp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (commit),
		.rx_byte(byte_s1),
		.flen   (flen_s1),
		.eof    (eof_s1),
		.res0   (res0),
		.res1   (res1),
		.res_n  (res_n)
	);

	snmprp_rqueue u_rqueue (
		.clk   (clk),
		.arst_n(arst_n),
		.push_n(push_n),
		.d0    (res0),
		.d1    (res1),
		.pop   (pop),
		.head  (head),
		.level (level)
	);

	assign result_valid    = level != 3'd0;
	assign result_kind     = head.kind;
	assign text_byte       = head.text;
	assign status          = head.status;
	assign host_error_code = head.code;
	assign last_result     = head.last;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= 3'd4)
		else $error("result queue overflow");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && level > 3'd2))
		else $error("input stalled without a full queue");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && res_n == 2'd2) |->
		(res0.kind != snmprp_pkg::KIND_STATUS && res1.kind == snmprp_pkg::KIND_STATUS
		&& !res0.last))
		else $error("two results from one request out of order");

	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		(!commit && pop) |=> level == $past(level) - 3'd1)
		else $error("queue level lost track");

endmodule
